// ----- rtl/rlsp_pkg.sv -----
// ----------------------------------------------------------------------------
// rlsp_pkg - shared types and constants for the RGBW LED strip serializer
// Frame geometry, command codes and the command queue entry.
// ----------------------------------------------------------------------------
package rlsp_pkg;

  // Strip geometry
  localparam int PIXELS         = 64;
  localparam int RESET_WORDS    = 64;
  localparam int BITS_PER_PIXEL = 32;
  localparam int PIX_BITS       = PIXELS * BITS_PER_PIXEL;
  localparam int FRAME_WORDS    = PIX_BITS + RESET_WORDS;

  localparam int POS_W  = $clog2(FRAME_WORDS);
  localparam int IDX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int BIT_SH = $clog2(BITS_PER_PIXEL);

  // Green is the top byte of a stored pixel word
  localparam int GREEN_LSB = 24;

  localparam logic [7:0] FORCED_GREEN   = 8'h4F;
  localparam logic [7:0] LOW_DUTY_RESET = 8'd30;

  // Command codes (tuser on the input stream)
  localparam logic [1:0] MODE_SET_ONE = 2'd0;
  localparam logic [1:0] MODE_SET_ALL = 2'd1;
  localparam logic [1:0] MODE_FRAME   = 2'd2;
  localparam logic [1:0] MODE_TICK    = 2'd3;

  // Command queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] idx;
    logic [31:0]      word;   // green, red, blue, white from msb down
  } item_t;

endpackage

// ----- rtl/rlsp_ram.sv -----
// ----------------------------------------------------------------------------
// rlsp_ram - generic simple dual port RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module rlsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rlsp_front.sv -----
// ----------------------------------------------------------------------------
// rlsp_front - input decode
// Unpacks the input word, drops out-of-range pixel writes, feeds the queue.
// ----------------------------------------------------------------------------
module rlsp_front (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [39:0]         s_tdata,
  input  logic [1:0]          s_tuser,
  input  logic                q_full,
  output logic                q_push,
  output rlsp_pkg::item_t     q_item
);

  logic [5:0] pixel_index;
  logic [7:0] red, green, blue, white;
  logic       keep;

  assign pixel_index = s_tdata[5:0];
  assign red         = s_tdata[13:6];
  assign green       = s_tdata[21:14];
  assign blue        = s_tdata[29:22];
  assign white       = s_tdata[37:30];

  // Only single-pixel writes can be out of range; those are swallowed here.
  always_comb begin
    keep = 1'b1;
    if (s_tuser == rlsp_pkg::MODE_SET_ONE) begin
      keep = (32'(pixel_index) < 32'(rlsp_pkg::PIXELS));
    end
  end

  assign s_tready    = !q_full;
  assign q_push      = s_tvalid && !q_full && keep;
  assign q_item.mode = s_tuser;
  assign q_item.idx  = rlsp_pkg::IDX_W'(pixel_index);
  assign q_item.word = {green, red, blue, white};

endmodule

// ----- rtl/rlsp_fifo.sv -----
// ----------------------------------------------------------------------------
// rlsp_fifo - command queue
// Short queue between decode and the frame engine.
// ----------------------------------------------------------------------------
module rlsp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rlsp_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output rlsp_pkg::item_t dout
);

  localparam int AW = rlsp_pkg::FIFO_AW;

  rlsp_pkg::item_t mem [rlsp_pkg::FIFO_DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;
  logic            do_push, do_pop;

  assign full    = (count == (AW+1)'(rlsp_pkg::FIFO_DEPTH));
  assign valid   = (count != '0);
  assign dout    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(rlsp_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/rlsp_back.sv -----
// ----------------------------------------------------------------------------
// rlsp_back - frame engine
// Executes queued commands: pixel store updates, frame control and ticks.
// ----------------------------------------------------------------------------
module rlsp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            low_duty_we,
  input  logic [7:0]      low_duty_wdata,
  input  logic            head_valid,
  input  rlsp_pkg::item_t head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,
  output logic            m_tuser,
  output logic            m_tlast
);

  localparam int POS_W = rlsp_pkg::POS_W;
  localparam int IDX_W = rlsp_pkg::IDX_W;
  localparam int SH    = rlsp_pkg::BIT_SH;

  logic [7:0]               low_duty;
  logic                     busy;
  logic [POS_W-1:0]         pos;
  logic                     g0_force;   // pixel 0 green overridden to the forced value
  logic [31:0]              fill;       // value from the last set-all
  logic [rlsp_pkg::PIXELS-1:0] vld;     // entry written since the last set-all

  // read stage
  logic                     b_valid, b_pixel, b_send, b_end, b_from_ram, b_alt;
  logic [SH-1:0]            b_bit;
  // output register
  logic                     o_valid, o_send, o_end;
  logic [8:0]               o_duty;

  logic                     is_tick, out_free, b_adv, tick_go;
  logic                     ram_we, ram_re, pix_sec, last_word;
  logic [IDX_W-1:0]         ridx;
  logic [SH-1:0]            bitpos;
  logic                     force_hit, alt_bit, from_ram, pix_bit;
  logic [31:0]              rdata;
  logic [8:0]               duty_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_duty <= rlsp_pkg::LOW_DUTY_RESET;
    end else if (low_duty_we) begin
      low_duty <= low_duty_wdata;
    end
  end

  assign is_tick  = (head.mode == rlsp_pkg::MODE_TICK);
  assign out_free = !o_valid || m_tready;
  assign b_adv    = !b_valid || out_free;
  assign tick_go  = head_valid && is_tick && b_adv;
  assign pop      = head_valid && (!is_tick || b_adv);
  assign ram_we   = head_valid && (head.mode == rlsp_pkg::MODE_SET_ONE);

  // bit selection for the current frame position
  assign pix_sec   = (pos < POS_W'(rlsp_pkg::PIX_BITS));
  assign last_word = (pos == POS_W'(rlsp_pkg::FRAME_WORDS - 1));
  assign ridx      = IDX_W'(pos >> SH);
  assign bitpos    = ~pos[SH-1:0];
  assign force_hit = g0_force && (ridx == '0) && (bitpos >= SH'(rlsp_pkg::GREEN_LSB));
  assign alt_bit   = force_hit ? rlsp_pkg::FORCED_GREEN[bitpos[2:0]] : fill[bitpos];
  assign from_ram  = vld[ridx] && !force_hit;
  assign ram_re    = tick_go;

  rlsp_ram #(
    .WIDTH (32),
    .DEPTH (rlsp_pkg::PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.idx),
    .wdata (head.word),
    .re    (ram_re),
    .raddr (ridx),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pos      <= '0;
      g0_force <= 1'b0;
      fill     <= '0;
      vld      <= '0;
    end else if (pop) begin
      unique case (head.mode)
        rlsp_pkg::MODE_SET_ONE: begin
          vld[head.idx] <= 1'b1;
          if (head.idx == '0) begin
            g0_force <= 1'b0;
          end
        end
        rlsp_pkg::MODE_SET_ALL: begin
          fill     <= head.word;
          vld      <= '0;
          g0_force <= 1'b0;
        end
        rlsp_pkg::MODE_FRAME: begin
          g0_force <= 1'b1;
          busy     <= !busy;
          pos      <= '0;
        end
        rlsp_pkg::MODE_TICK: begin
          if (busy) begin
            if (last_word) begin
              busy <= 1'b0;
              pos  <= '0;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
      endcase
    end
  end

  // read stage: waits on the store's registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_adv) begin
      b_valid <= tick_go;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      b_pixel    <= busy && pix_sec;
      b_send     <= busy;
      b_end      <= busy && last_word;
      b_from_ram <= from_ram;
      b_alt      <= alt_bit;
      b_bit      <= bitpos;
    end
  end

  assign pix_bit   = b_from_ram ? rdata[b_bit] : b_alt;
  assign duty_next = !b_pixel ? 9'd0 :
                     pix_bit  ? {low_duty, 1'b0} : {1'b0, low_duty};

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && b_valid) begin
      o_duty <= duty_next;
      o_send <= b_send;
      o_end  <= b_end;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {7'd0, o_duty};
  assign m_tuser  = o_send;
  assign m_tlast  = o_end;

  // ---- assertions ----
  a_end_sending: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_end |-> o_send)
    else $error("frame end flagged on a word outside a frame");

  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !busy |-> pos == '0)
    else $error("frame position moved while idle");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < POS_W'(rlsp_pkg::FRAME_WORDS))
    else $error("frame position past frame length");

  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store read and write in the same cycle");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !out_free |=> b_valid && !$past(ram_re))
    else $error("read stage lost a word or reread while stalled");

endmodule

// ----- rtl/rgbw_led_strip_pwm_serializer.sv -----
// ----------------------------------------------------------------------------
// rgbw_led_strip_pwm_serializer - RGBW LED strip PWM bit serializer
// Holds the pixel store and turns each timer tick into one PWM duty word.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one command word per transfer. tuser carries the mode:
//   set one pixel, set all pixels, start/abort frame, or bit tick. Only ticks
//   produce an output word; the others update state silently.
//   Output stream (m_*): duty compare value in tdata, tuser high while a frame
//   is sending, tlast on the final reset-gap word of a frame.
//   low_duty_we/low_duty_wdata write the zero-bit compare count (one bit uses
//   twice that); write it only while the block is idle.
// Timing:
//   A tick's word reaches m_* through the queue entry, then the store read
//   stage, then the output register. One command per cycle is sustained
//   while m_tready does not stall: decode feeds a 2-entry queue, the frame
//   engine takes one command a cycle and the pixel RAM sees at most one access
//   per command. Set-all needs no per-pixel writes (fill register plus per-pixel valid bits).
// Reset: synchronous, active high. Store reads as zero, idle, low_duty = 30.
// Back pressure: a stalled m_tready holds the output word; the next tick waits
//   in the read stage, later ticks back up in the 2-entry queue, and s_tready
//   drops once the queue is full. Nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
module rgbw_led_strip_pwm_serializer (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        low_duty_we,
  input  logic [7:0]  low_duty_wdata,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pixel_index[5:0], red, green, blue, white, 2'b0
  input  logic [1:0]  s_tuser,   // mode
  // duty stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // duty[8:0], 7'b0
  output logic        m_tuser,   // sending
  output logic        m_tlast    // frame_end
);

  logic            q_full, q_push, q_pop, q_valid;
  rlsp_pkg::item_t q_in, q_out;

  // decode and filter
  rlsp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // decouples input acceptance from the engine's stalls
  rlsp_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_out)
  );

  // pixel store, frame sequencing and output register
  rlsp_back u_engine (
    .clk            (clk),
    .rst            (rst),
    .low_duty_we    (low_duty_we),
    .low_duty_wdata (low_duty_wdata),
    .head_valid     (q_valid),
    .head           (q_out),
    .pop            (q_pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast)
  );

endmodule
